[hdl/assert_macros.svh]
// Assertion macros of the hash set binner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hdl/mhsb_pkg.sv]
// Shared constants, types and helper functions of the hash set binner.
package mhsb_pkg;

	// Hash constants
	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int          WORD_SHIFT  = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;

	// Register reset values
	localparam logic [31:0] SEED_RESET      = 32'd419;
	localparam logic [15:0] SET_COUNT_RESET = 16'd1;

	// Configuration register indexes
	localparam int          REG_IDX_W     = 1;
	localparam logic [REG_IDX_W-1:0] REG_HASH_SEED = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_SET_COUNT = 1'd1;

	// Hash queue depth default
	localparam int QUEUE_DEPTH_DEF = 2;

	// Remainder unit: quotient bits retired per cycle and loop steps per hash
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = 32 / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [31:0] hash_seed;
		logic [15:0] set_count;
	} cfg_t;

	typedef struct packed {
		logic [31:0] hash;
	} hq_entry_t;

	// Multiply by the mixing constant, keeping the low 32 bits
	function automatic logic [31:0] mul_mix(input logic [31:0] a);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, MIX_MUL};
		return p[31:0];
	endfunction

endpackage

[hdl/murmur2_hash_set_binner_unit.sv]
// Top level of the 32-bit MurmurHash2 set binner: config registers, front, queue, back.
// Keys stream in as little-endian 32-bit words; a word of four bytes or more passes
// through F_IDLE and F_WORD in the front end (split multiply chain), a short word
// through F_IDLE alone, and the last word of a key also through F_FIN (avalanche
// multiply) and F_PUSH (hand-off to the hash queue). Each finished hash then passes
// through the back end: B_IDLE takes it from the queue, B_DIV runs eight steps of the
// remainder loop, which retires four quotient bits per cycle, and B_OUT loads the
// output register; no new hash is taken before that load. The hash queue holds QUEUE_DEPTH
// finished hashes, so the front end keeps taking words while the back end divides and
// the queue has room; with short keys the remainder loop sets the sustained rate. The
// result sits in an output register until taken. Write configuration only while no key
// is in flight.
`include "assert_macros.svh"

module murmur2_hash_set_binner_unit #(
	parameter int QUEUE_DEPTH = mhsb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [47:0]                    s_tdata,  // data_word, byte_count, key_length
	input  logic                           s_tlast,  // last_word
	input  logic                           s_tuser,  // first_word
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [47:0]                    m_tdata,  // hash_value, set_index
	input  logic                           cfg_we,
	input  logic [mhsb_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import mhsb_pkg::*;

	cfg_t        cfg_q;
	logic        q_push_valid;
	logic        q_push_ready;
	hq_entry_t   q_push_data;
	logic        q_pop_valid;
	logic        q_pop_ready;
	hq_entry_t   q_pop_data;
	logic [31:0] hash_value;
	logic [15:0] set_index;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hash_seed <= SEED_RESET;
			cfg_q.set_count <= SET_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HASH_SEED: cfg_q.hash_seed <= cfg_data;
				REG_SET_COUNT: cfg_q.set_count <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	mhsb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_word  (s_tdata[31:0]),
		.byte_count (s_tdata[34:32]),
		.key_length (s_tdata[44:35]),
		.first_word (s_tuser),
		.last_word  (s_tlast),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	mhsb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	mhsb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.hash_value (hash_value),
		.set_index  (set_index)
	);

	assign m_tdata = {set_index, hash_value};

	// The front end takes no word while a finished hash waits for the queue
	`ASSERT_IMPLIES(a_ready_not_pushing, clk, arst_n, s_tready, !q_push_valid, "front ready while pushing")

	// A hash pushed into the queue is visible to the back end next cycle
	`ASSERT_NEXT(a_push_then_pop_valid, clk, arst_n, q_push_valid && q_push_ready, q_pop_valid, "queue lost an entry")

	// A delivered set index stays below the set count
	`ASSERT_IMPLIES(a_index_in_range, clk, arst_n, m_tvalid && (cfg_q.set_count != 16'd0), m_tdata[47:32] < cfg_q.set_count, "set index out of range")

endmodule

[hdl/mhsb_front.sv]
// Front end: accepts key words and runs the word, tail and final mixing.
module mhsb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  mhsb_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         data_word,
	input  logic [2:0]          byte_count,
	input  logic [9:0]          key_length,
	input  logic                first_word,
	input  logic                last_word,
	output logic                push_valid,
	input  logic                push_ready,
	output mhsb_pkg::hq_entry_t push_data
);
	import mhsb_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE,
		F_WORD,
		F_FIN,
		F_PUSH
	} fstate_t;

	fstate_t     state_q;
	logic [31:0] run_q;
	logic        last_q;
	logic [31:0] ta_s1;
	logic [31:0] tb_s1;
	logic [31:0] h_q;
	logic [31:0] fin_q;

	logic [31:0] base;
	logic        full;
	logic [31:0] tail_x;
	logic [31:0] mul_p;
	logic [31:0] tail_h;
	logic [31:0] ta_mix;
	logic [31:0] word_h;
	logic [31:0] fin_mul;

	// Seed or continue, then select the byte lanes that a short word brings
	always_comb begin
		base   = first_word ? (cfg.hash_seed ^ {22'd0, key_length}) : run_q;
		full   = (byte_count >= 3'd4);
		tail_x = base ^ {8'd0,
			(byte_count >= 3'd3) ? data_word[23:16] : 8'd0,
			(byte_count >= 3'd2) ? data_word[15:8]  : 8'd0,
			(byte_count >= 3'd1) ? data_word[7:0]   : 8'd0};
		mul_p  = mul_mix(full ? base : tail_x);
		tail_h = (byte_count != 3'd0) ? mul_p : base;
	end

	// Second half of the word step and first half of the avalanche
	always_comb begin
		ta_mix  = ta_s1 ^ (ta_s1 >> WORD_SHIFT);
		word_h  = tb_s1 ^ mul_mix(ta_mix);
		fin_mul = mul_mix(h_q ^ (h_q >> FIN_SHIFT_A));
	end

	assign in_ready       = (state_q == F_IDLE);
	assign push_valid     = (state_q == F_PUSH);
	assign push_data.hash = fin_q ^ (fin_q >> FIN_SHIFT_B);

	// Sequence one word through the shared mixing steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			run_q   <= '0;
			last_q  <= 1'b0;
			ta_s1   <= '0;
			tb_s1   <= '0;
			h_q     <= '0;
			fin_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						last_q <= last_word;
						ta_s1  <= mul_mix(data_word);
						tb_s1  <= mul_p;
						if (full) begin
							state_q <= F_WORD;
						end else if (last_word) begin
							h_q     <= tail_h;
							state_q <= F_FIN;
						end else begin
							run_q <= tail_h;
						end
					end
				end
				F_WORD: begin
					if (last_q) begin
						h_q     <= word_h;
						state_q <= F_FIN;
					end else begin
						run_q   <= word_h;
						state_q <= F_IDLE;
					end
				end
				F_FIN: begin
					fin_q   <= fin_mul;
					run_q   <= '0;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/mhsb_queue.sv]
// Short queue of finished hashes between the front and back ends.
module mhsb_queue #(
	parameter int DEPTH = mhsb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mhsb_pkg::hq_entry_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mhsb_pkg::hq_entry_t pop_data
);
	import mhsb_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	hq_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store an entry on push
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/mhsb_back.sv]
// Back end: reduces each finished hash into a set index and holds the result.
module mhsb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mhsb_pkg::cfg_t      cfg,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  mhsb_pkg::hq_entry_t pop_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         hash_value,
	output logic [15:0]         set_index
);
	import mhsb_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_OUT
	} bstate_t;

	bstate_t              state_q;
	logic [31:0]          hash_q;
	logic [31:0]          mag_q;
	logic [15:0]          rem_q;
	logic [15:0]          div_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_v_q;
	logic [31:0]          out_hash_q;
	logic [15:0]          out_idx_q;

	logic [31:0] mag_nx;
	logic [15:0] rem_nx;
	logic [16:0] trial;
	logic [15:0] idx;
	logic        can_load;

	// Retire DIV_BITS quotient bits of the magnitude per cycle
	always_comb begin
		mag_nx = mag_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {rem_nx, mag_nx[31]};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_nx = trial[15:0];
			mag_nx = {mag_nx[30:0], 1'b0};
		end
	end

	// Fold the remainder back for a negative hash; no sets gives index zero
	always_comb begin
		if (div_q == 16'd0) begin
			idx = 16'd0;
		end else if (!neg_q || rem_q == 16'd0) begin
			idx = rem_q;
		end else begin
			idx = div_q - rem_q;
		end
	end

	assign can_load   = !out_v_q || out_ready;
	assign pop_ready  = (state_q == B_IDLE);
	assign out_valid  = out_v_q;
	assign hash_value = out_hash_q;
	assign set_index  = out_idx_q;

	// Take a hash, run the remainder loop, load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			hash_q     <= '0;
			mag_q      <= '0;
			rem_q      <= '0;
			div_q      <= '0;
			neg_q      <= 1'b0;
			cnt_q      <= '0;
			out_v_q    <= 1'b0;
			out_hash_q <= '0;
			out_idx_q  <= '0;
		end else begin
			// Raise on load, drop once the beat is taken
			if (state_q == B_OUT && can_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						hash_q  <= pop_data.hash;
						neg_q   <= pop_data.hash[31];
						mag_q   <= pop_data.hash[31] ? (~pop_data.hash + 32'd1)
							: pop_data.hash;
						rem_q   <= '0;
						div_q   <= cfg.set_count;
						cnt_q   <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					mag_q <= mag_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (can_load) begin
						out_hash_q <= hash_q;
						out_idx_q  <= idx;
						state_q    <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

[dv/tb_top.sv]
// Self-checking testbench of the MurmurHash2 set binner: stream stimulus, hash predictor, checker.

typedef struct packed {
	logic [31:0] word;
	logic [2:0]  nbytes;
	logic [9:0]  klen;
	logic        first;
	logic        last;
} key_beat_t;

// Packed so that it lines up with m_tdata: hash_value low, set_index high
typedef struct packed {
	logic [15:0] set_idx;
	logic [31:0] hash;
} bin_result_t;

// Predicts hash and set index per key and checks them against the result stream
class murmur_bin_board;
	logic [31:0] seed;
	logic [15:0] sets;
	logic [31:0] run_hash;
	bin_result_t bin_result_q[$];
	int          errors;

	function new();
		seed     = mhsb_pkg::SEED_RESET;
		sets     = mhsb_pkg::SET_COUNT_RESET;
		run_hash = 32'd0;
		errors   = 0;
	endfunction

	function void set_regs(logic [31:0] new_seed, logic [15:0] new_sets);
		seed = new_seed;
		sets = new_sets;
	endfunction

	function logic [31:0] fold_word(logic [31:0] h, logic [31:0] k);
		k = k * mhsb_pkg::MIX_MUL;
		k = k ^ (k >> mhsb_pkg::WORD_SHIFT);
		k = k * mhsb_pkg::MIX_MUL;
		h = h * mhsb_pkg::MIX_MUL;
		return h ^ k;
	endfunction

	// Fall-through mixing of the trailing bytes
	function logic [31:0] fold_tail(logic [31:0] h, logic [31:0] w, logic [2:0] n);
		if (n >= 3) h = h ^ {8'd0, w[23:16], 16'd0};
		if (n >= 2) h = h ^ {16'd0, w[15:8], 8'd0};
		if (n >= 1) begin
			h = h ^ {24'd0, w[7:0]};
			h = h * mhsb_pkg::MIX_MUL;
		end
		return h;
	endfunction

	function logic [31:0] avalanche(logic [31:0] h);
		h = h ^ (h >> mhsb_pkg::FIN_SHIFT_A);
		h = h * mhsb_pkg::MIX_MUL;
		h = h ^ (h >> mhsb_pkg::FIN_SHIFT_B);
		return h;
	endfunction

	// Non-negative remainder of the hash taken as a signed value
	function logic [15:0] bin_index(logic [31:0] h, logic [15:0] n);
		logic [31:0] mag;
		logic [31:0] rem;
		if (n == 16'd0) return 16'd0;
		if (!h[31]) begin
			rem = h % {16'd0, n};
			return rem[15:0];
		end
		mag = 32'd0 - h;
		rem = mag % {16'd0, n};
		if (rem == 32'd0) return 16'd0;
		return n - rem[15:0];
	endfunction

	function void note_beat(key_beat_t b);
		logic [31:0] h;
		logic [2:0]  n;
		bin_result_t r;
		h = b.first ? (seed ^ {22'd0, b.klen}) : run_hash;
		n = (b.nbytes > 3'd4) ? 3'd4 : b.nbytes;
		if (n == 3'd4) h = fold_word(h, b.word);
		else h = fold_tail(h, b.word, n);
		if (!b.last) begin
			run_hash = h;
			return;
		end
		r.hash    = avalanche(h);
		r.set_idx = bin_index(r.hash, sets);
		run_hash  = 32'd0;
		bin_result_q.push_back(r);
	endfunction

	function void flag(string what, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
	endfunction

	function void check_result(bin_result_t got);
		bin_result_t want;
		if (bin_result_q.size() == 0) begin
			flag("unexpected result hash", 32'hx, got.hash);
			return;
		end
		want = bin_result_q.pop_front();
		if (got.hash !== want.hash) flag("hash_value", want.hash, got.hash);
		if (got.set_idx !== want.set_idx)
			flag("set_index", {16'd0, want.set_idx}, {16'd0, got.set_idx});
	endfunction

	function int pending();
		return bin_result_q.size();
	endfunction
endclass

module tb_top;
	localparam int LIMIT  = 1000000;
	localparam int SETTLE = 100;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [47:0]                    s_tdata   = '0;  // data_word, byte_count, key_length
	logic                           s_tlast   = 1'b0; // last_word
	logic                           s_tuser   = 1'b0; // first_word
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [47:0]                    m_tdata;         // hash_value, set_index
	logic                           cfg_we    = 1'b0;
	logic [mhsb_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                    cfg_data  = '0;

	murmur_bin_board sb = new();
	bit calm       = 1'b0;
	int rx_hold    = 0;
	int beats_sent = 0;

	murmur2_hash_set_binner_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Offer one beat, hold it until taken, then maybe go idle for a burst
	task automatic send_beat(logic [31:0] word, logic [2:0] n, logic [9:0] klen,
	                         logic first, logic last);
		key_beat_t b;
		int gap;
		b = '{word: word, nbytes: n, klen: klen, first: first, last: last};
		s_tvalid <= 1'b1;
		s_tdata  <= {3'd0, klen, n, word};
		s_tlast  <= last;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		sb.note_beat(b);
		beats_sent++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Well-formed key of klen bytes; the length field is sometimes off
	task automatic send_key(int klen);
		int nwords;
		logic [9:0] lfield;
		logic [2:0] n;
		nwords = (klen == 0) ? 1 : (klen + 3) / 4;
		lfield = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, 1023)) : 10'(klen);
		for (int i = 0; i < nwords; i++) begin
			if (i < nwords - 1) n = 3'd4;
			else if (klen == 0) n = 3'd0;
			else if (klen % 4 == 0) n = 3'd4;
			else n = 3'(klen % 4);
			send_beat($urandom, n, lfield, i == 0, i == nwords - 1);
		end
	endtask

	function automatic int pick_len();
		if ($urandom_range(0, 199) == 0) return $urandom_range(200, 1023);
		return $urandom_range(0, 24);
	endfunction

	function automatic logic [15:0] pick_sets();
		case ($urandom_range(0, 5))
			0: return 16'd1;
			1: return 16'd65535;
			2: return 16'd2;
			3: return 16'($urandom_range(3, 17));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	// Stop offering, wait for every result, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_config(logic [31:0] seed, logic [15:0] sets);
		cfg_we    <= 1'b1;
		cfg_index <= mhsb_pkg::REG_HASH_SEED;
		cfg_data  <= seed;
		@(posedge clk);
		cfg_index <= mhsb_pkg::REG_SET_COUNT;
		cfg_data  <= {16'd0, sets};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_regs(seed, sets);
	endtask

	// Result side: check taken beats, stall in random bursts or on a long hold
	initial begin : rx_side
		int idle_left;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check_result(bin_result_t'(m_tdata));
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (idle_left > 0) begin
				m_tready <= 1'b0;
				idle_left--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) idle_left = $urandom_range(1, 15);
			end
		end
	end

	// Abort a hung run
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles <= LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int target;
		bit paused;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: continue from zero without a first mark, empty key, short mid word
		send_beat($urandom, 3'd4, 10'd0, 1'b0, 1'b0);
		send_beat($urandom, 3'd2, 10'd0, 1'b0, 1'b1);
		send_beat(32'h0, 3'd0, 10'd0, 1'b1, 1'b1);
		send_beat($urandom, 3'd3, 10'd5, 1'b1, 1'b0);
		send_beat(32'hffffffff, 3'd4, 10'd5, 1'b0, 1'b1);
		drain();

		// Top extremes, oversized byte counts, length mismatch
		write_config(32'hffffffff, 16'd65535);
		send_beat(32'hffffffff, 3'd4, 10'd1023, 1'b1, 1'b0);
		send_beat(32'h0, 3'd7, 10'd0, 1'b0, 1'b0);
		send_beat(32'hffffffff, 3'd5, 10'd1023, 1'b0, 1'b0);
		send_beat(32'h80808080, 3'd6, 10'd0, 1'b0, 1'b0);
		send_beat(32'h000000ff, 3'd1, 10'd0, 1'b0, 1'b1);
		send_beat(32'h0, 3'd4, 10'd0, 1'b1, 1'b1);
		send_beat(32'h000000ff, 3'd1, 10'd1023, 1'b1, 1'b1);
		send_beat(32'hffffffff, 3'd3, 10'd1023, 1'b0, 1'b1);
		drain();

		// Zero seed and zero set count
		write_config(32'h0, 16'd0);
		send_beat(32'h0000ffff, 3'd2, 10'd2, 1'b1, 1'b1);
		send_beat($urandom, 3'd4, 10'd8, 1'b1, 1'b0);
		send_beat($urandom, 3'd4, 10'd8, 1'b0, 1'b1);
		send_beat(32'hffffffff, 3'd0, 10'd1023, 1'b1, 1'b1);
		drain();

		write_config($urandom, 16'd2);
		send_key(7);
		send_key(12);
		send_key(1);
		drain();

		// Random phases: mostly well-formed keys, some noise beats
		for (int ph = 0; ph < 6; ph++) begin
			write_config($urandom, pick_sets());
			if (ph == 2) rx_hold = 600;
			if (ph == 5) calm = 1'b1;
			target = beats_sent + 300;
			while (beats_sent < target) begin
				if ($urandom_range(0, 99) < 12)
					send_beat($urandom, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)),
					          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				else
					send_key(pick_len());
				if (ph == 3 && !paused && beats_sent > target - 150) begin
					drain();
					paused = 1'b1;
				end
			end
			// Close any open key before the settings change
			send_key(pick_len() % 9);
			drain();
		end

		if (sb.errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
